FILE: sv/rfb_pkg.sv
// Shared types, constants and codes of the relay forward backoff block.
package rfb_pkg;

   localparam int PACKET_BYTES_DEFAULT = 11;
   localparam int DELAY_BITS = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int POS_ADDR = 2;
   localparam int POS_TYPE = 3;
   localparam int POS_SEQ = 4;
   localparam int POS_TTL = 5;

   localparam logic [7:0] TYPE_DATA = 8'h01;
   localparam logic [7:0] TYPE_ACK = 8'h02;
   localparam logic [7:0] TTL_DROP = 8'h00;

   localparam logic [DELAY_BITS-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [DELAY_BITS-1:0] LFSR_SEED = 16'hACE1;

   localparam logic [2:0] REG_RELAY_ID = 3'd0;
   localparam logic [2:0] REG_DATA_MIN = 3'd1;
   localparam logic [2:0] REG_DATA_MAX = 3'd2;
   localparam logic [2:0] REG_ACK_MIN = 3'd3;
   localparam logic [2:0] REG_ACK_MAX = 3'd4;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_LAST,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   typedef struct packed {
      logic                  push;
      logic                  pop;
      logic                  full;
      logic                  valid;
   } queue_ctl_type;

   typedef struct packed {
      logic [7:0]            relay_id;
      logic [DELAY_BITS-1:0] data_min;
      logic [DELAY_BITS-1:0] data_max;
      logic [DELAY_BITS-1:0] ack_min;
      logic [DELAY_BITS-1:0] ack_max;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_JUDGE,
      ST_DIVIDE,
      ST_CHECK,
      ST_SEND
   } back_state_type;

endpackage

FILE: sv/rfb_front.sv
// Front end: accepts input words, tracks packet position and tags commands.
module rfb_front
   import rfb_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_word_type req_word,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   localparam int IDX_BITS = $clog2(PACKET_BYTES);

   logic [IDX_BITS-1:0] pos_ff;
   logic [IDX_BITS-1:0] pos_in;
   logic                at_end;

   assign q_push = push && !q_full;
   assign at_end = (pos_ff == IDX_BITS'(PACKET_BYTES - 1));

   always_comb begin
      pos_in = pos_ff;
      q_cmd.data = req_word.rx_byte;
      q_cmd.kind = CMD_TICK;
      if (req_word.req_type == REQ_BYTE) begin
         q_cmd.kind = at_end ? CMD_LAST : CMD_BYTE;
      end
      if (q_push && req_word.req_type == REQ_BYTE) begin
         pos_in = at_end ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: sv/rfb_queue.sv
// Two-entry command queue between front and back.
module rfb_queue
   import rfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    valid,
   output cmd_type pop_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/rfb_remainder.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module rfb_remainder
   import rfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DELAY_BITS-1:0] dividend,
   input  logic [DELAY_BITS-1:0] divisor,
   output logic                  done,
   output logic [DELAY_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(DELAY_BITS + 1);

   logic [DELAY_BITS-1:0] rem_ff;
   logic [DELAY_BITS-1:0] rem_in;
   logic [DELAY_BITS-1:0] dvd_ff;
   logic [DELAY_BITS-1:0] dvd_in;
   logic [DELAY_BITS-1:0] dvs_ff;
   logic [DELAY_BITS-1:0] dvs_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [DELAY_BITS:0]   trial;

   assign done = done_ff;
   assign remainder = rem_ff;
   assign trial = {rem_ff, dvd_ff[DELAY_BITS-1]};

   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         count_in = CNT_BITS'(DELAY_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DELAY_BITS'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[DELAY_BITS-1:0];
         end
         dvd_in = {dvd_ff[DELAY_BITS-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

endmodule

FILE: sv/rfb_back.sv
// Back end: gathers packets, judges them, times the hold and sends the packet.
module rfb_back
   import rfb_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   input  logic         pop,
   output logic         empty,
   output rsp_word_type rsp_word
);

   localparam int IDX_BITS = $clog2(PACKET_BYTES);
   localparam logic [DELAY_BITS-1:0] TICK_MAX = '1;

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [7:0]            rx_line_ff [PACKET_BYTES];
   logic [7:0]            rx_line_in [PACKET_BYTES];
   logic [7:0]            held_ff [PACKET_BYTES];
   logic [7:0]            held_in [PACKET_BYTES];
   logic                  held_valid_ff;
   logic                  held_valid_in;
   logic [DELAY_BITS-1:0] elapsed_ff;
   logic [DELAY_BITS-1:0] elapsed_in;
   logic [DELAY_BITS-1:0] wait_ff;
   logic [DELAY_BITS-1:0] wait_in;
   logic [DELAY_BITS-1:0] lfsr_ff;
   logic [DELAY_BITS-1:0] lfsr_in;
   logic [DELAY_BITS-1:0] lo_ff;
   logic [DELAY_BITS-1:0] lo_in;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [IDX_BITS-1:0]   idx_in;
   rsp_word_type          rsp_ff;
   rsp_word_type          rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   logic                  take;
   logic                  force_ack;
   logic                  use_ack;
   logic                  use_data;
   logic [DELAY_BITS-1:0] sel_lo;
   logic [DELAY_BITS-1:0] sel_hi;
   logic [DELAY_BITS-1:0] lfsr_next;
   logic                  div_start;
   logic                  div_done;
   logic [DELAY_BITS-1:0] div_rem;
   logic                  load;
   logic                  expired;
   logic                  send_last;
   logic [7:0]            send_byte;

   rfb_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lfsr_next),
      .divisor   (DELAY_BITS'(sel_hi - sel_lo)),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign empty = !rsp_valid_ff;
   assign rsp_word = rsp_ff;
   assign load = !rsp_valid_ff || pop;
   assign expired = held_valid_ff && (elapsed_ff >= wait_ff);
   assign send_last = (idx_ff == IDX_BITS'(PACKET_BYTES - 1));
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);

   always_comb begin
      take = 1'b0;
      force_ack = 1'b0;
      if (rx_line_ff[POS_TTL] != TTL_DROP) begin
         if (!held_valid_ff) begin
            take = 1'b1;
         end else if (held_ff[POS_TYPE] == TYPE_DATA) begin
            if (rx_line_ff[POS_TYPE] == TYPE_ACK && rx_line_ff[POS_SEQ] == held_ff[POS_SEQ]) begin
               take = 1'b1;
               force_ack = 1'b1;
            end else if (rx_line_ff[POS_SEQ] > held_ff[POS_SEQ]) begin
               take = 1'b1;
            end
         end else if (held_ff[POS_TYPE] == TYPE_ACK) begin
            take = (rx_line_ff[POS_SEQ] > held_ff[POS_SEQ]);
         end
      end
      use_ack = force_ack || (rx_line_ff[POS_TYPE] == TYPE_ACK);
      use_data = !use_ack && (rx_line_ff[POS_TYPE] == TYPE_DATA);
      sel_lo = use_ack ? cfg.ack_min : cfg.data_min;
      sel_hi = use_ack ? cfg.ack_max : cfg.data_max;
   end

   always_comb begin
      send_byte = held_ff[0];
      if (idx_ff == IDX_BITS'(POS_ADDR)) begin
         send_byte = cfg.relay_id;
      end else if (idx_ff == IDX_BITS'(POS_TTL)) begin
         send_byte = held_ff[0] - 8'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_cmd.kind == CMD_LAST) ? ST_JUDGE : ST_CHECK;
            end
         end
         ST_JUDGE: begin
            if (take && (use_ack || use_data) && sel_hi > sel_lo) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = expired ? ST_SEND : ST_IDLE;
         end
         ST_SEND: begin
            if (load && send_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rx_line_in = rx_line_ff;
      held_in = held_ff;
      held_valid_in = held_valid_ff;
      elapsed_in = elapsed_ff;
      wait_in = wait_ff;
      lfsr_in = lfsr_ff;
      lo_in = lo_ff;
      idx_in = idx_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = pop ? 1'b0 : rsp_valid_ff;
      q_pop = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
            if (q_valid) begin
               if (q_cmd.kind == CMD_TICK) begin
                  if (elapsed_ff != TICK_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
               end else begin
                  for (int i = 0; i < PACKET_BYTES - 1; i++) begin
                     rx_line_in[i] = rx_line_ff[i+1];
                  end
                  rx_line_in[PACKET_BYTES-1] = q_cmd.data;
               end
            end
         end
         ST_JUDGE: begin
            if (take) begin
               held_in = rx_line_ff;
               held_valid_in = 1'b1;
               elapsed_in = '0;
               if (use_ack || use_data) begin
                  lfsr_in = lfsr_next;
                  lo_in = sel_lo;
                  if (sel_hi > sel_lo) begin
                     div_start = 1'b1;
                  end else begin
                     wait_in = sel_lo;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wait_in = lo_ff + div_rem;
            end
         end
         ST_CHECK: begin
            idx_in = '0;
         end
         ST_SEND: begin
            if (load) begin
               rsp_in.tx_byte = send_byte;
               rsp_in.tx_last = send_last;
               rsp_valid_in = 1'b1;
               for (int i = 0; i < PACKET_BYTES - 1; i++) begin
                  held_in[i] = held_ff[i+1];
               end
               idx_in = idx_ff + 1'b1;
               if (send_last) begin
                  held_valid_in = 1'b0;
                  idx_in = '0;
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_valid_ff <= 1'b0;
         elapsed_ff <= '0;
         wait_ff <= '0;
         lfsr_ff <= LFSR_SEED;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_valid_ff <= held_valid_in;
         elapsed_ff <= elapsed_in;
         wait_ff <= wait_in;
         lfsr_ff <= lfsr_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_line_ff <= rx_line_in;
      held_ff <= held_in;
      lo_ff <= lo_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: sv/relay_forward_backoff.sv
// Top level of the relay forward backoff block: register port, front, queue and back.
//
// channel   ports                            accepted when
// req       push, full, req_word             push && !full
// rsp       empty, pop, rsp_word             pop && !empty
// csr       psel, penable, pwrite, paddr,    psel && penable && pwrite && pready
//           pwdata, prdata, pready
//
// A byte or tick passes through the idle and check states of the back end; a byte
// that completes a packet also passes through the judge state, and through the divide
// state while a delay draw runs the remainder unit. A send moves PACKET_BYTES words,
// one per cycle through the output register while the output is not stalled.
// Reset is synchronous; no clearing pass runs after it. The two-entry command queue
// lets input words arrive while the back end works or waits on a stalled output.
module relay_forward_backoff
   import rfb_pkg::*;
#(
   parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  req_word_type             req_word,
   output logic                     empty,
   input  logic                     pop,
   output rsp_word_type             rsp_word,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   queue_ctl_type qctl;
   cmd_type       push_cmd;
   cmd_type       pop_cmd;
   logic [2:0]    reg_index;

   assign pready = 1'b1;
   assign full = qctl.full;
   assign reg_index = paddr[CSR_ADDR_BITS-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_index)
            REG_RELAY_ID: cfg_in.relay_id = pwdata[7:0];
            REG_DATA_MIN: cfg_in.data_min = pwdata[DELAY_BITS-1:0];
            REG_DATA_MAX: cfg_in.data_max = pwdata[DELAY_BITS-1:0];
            REG_ACK_MIN:  cfg_in.ack_min = pwdata[DELAY_BITS-1:0];
            REG_ACK_MAX:  cfg_in.ack_max = pwdata[DELAY_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_RELAY_ID: prdata = CSR_DATA_BITS'(cfg_ff.relay_id);
         REG_DATA_MIN: prdata = CSR_DATA_BITS'(cfg_ff.data_min);
         REG_DATA_MAX: prdata = CSR_DATA_BITS'(cfg_ff.data_max);
         REG_ACK_MIN:  prdata = CSR_DATA_BITS'(cfg_ff.ack_min);
         REG_ACK_MAX:  prdata = CSR_DATA_BITS'(cfg_ff.ack_max);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfb_front #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_word (req_word),
      .q_full   (qctl.full),
      .q_push   (qctl.push),
      .q_cmd    (push_cmd)
   );

   rfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (qctl.push),
      .push_cmd (push_cmd),
      .pop      (qctl.pop),
      .full     (qctl.full),
      .valid    (qctl.valid),
      .pop_cmd  (pop_cmd)
   );

   rfb_back #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (qctl.valid),
      .q_cmd    (pop_cmd),
      .q_pop    (qctl.pop),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

endmodule

FILE: sv/rfb_checker.sv
// Port-level checker of the relay forward backoff block and its bind.
module rfb_checker
   import rfb_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     push,
   input logic                     full,
   input req_word_type             req_word,
   input logic                     empty,
   input logic                     pop,
   input rsp_word_type             rsp_word,
   input logic                     psel,
   input logic                     penable,
   input logic                     pwrite,
   input logic [CSR_ADDR_BITS-1:0] paddr,
   input logic [CSR_DATA_BITS-1:0] pwdata,
   input logic [CSR_DATA_BITS-1:0] prdata,
   input logic                     pready
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_word)))
      else $error("waiting word changed");

   a_ready_high: assert property (@(posedge clock) disable iff (reset)
      (psel && penable) |-> pready)
      else $error("register access stalled");

endmodule

bind relay_forward_backoff rfb_checker u_checker (.*);

FILE: tb/relay_forward_backoff_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the relay forward backoff block, with a built-in predictor.
module relay_forward_backoff_tb;
   import rfb_pkg::*;

   localparam int NBYTES = PACKET_BYTES_DEFAULT;
   localparam int SETTLE_CYCLES = 80;
   localparam int MAX_SHOWN = 10;
   localparam int TOTAL_WORDS = 300;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   req_word_type             req_word = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   rsp_word_type             rsp_word;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   cfg_type                  cfg_now = '0;
   logic [7:0]               rx_buf [NBYTES];
   logic [7:0]               slot_buf [NBYTES];
   int                       rx_pos = 0;
   bit                       slot_full = 1'b0;
   logic [DELAY_BITS-1:0]    ticks_since = '0;
   logic [DELAY_BITS-1:0]    hold_limit = '0;
   logic [DELAY_BITS-1:0]    lfsr = LFSR_SEED;
   rsp_word_type             forward_q [$];
   rsp_word_type             head_word;

   int                       errors = 0;
   int                       words_sent = 0;
   int                       rsp_holdoff = 0;
   bit                       req_eager = 1'b0;
   bit                       rsp_eager = 1'b0;
   logic [7:0]               seq_base = 8'h00;

   relay_forward_backoff #(.PACKET_BYTES(NBYTES)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_word(req_word),
      .empty   (empty),
      .pop     (pop),
      .rsp_word(rsp_word),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #1 clock = ~clock;

   function automatic void note_error(input string msg);
      if (errors < MAX_SHOWN) $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endfunction

   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic logic [DELAY_BITS-1:0] next_delay(input logic [DELAY_BITS-1:0] lo,
                                                        input logic [DELAY_BITS-1:0] hi);
      logic [DELAY_BITS-1:0] span;
      lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
      if (hi <= lo) return lo;
      span = hi - lo;
      return lo + (lfsr % span);
   endfunction

   function automatic void take_slot(input bit force_ack);
      for (int k = 0; k < NBYTES; k++) slot_buf[k] = rx_buf[k];
      slot_full = 1'b1;
      ticks_since = '0;
      if (force_ack || rx_buf[POS_TYPE] == TYPE_ACK) begin
         hold_limit = next_delay(cfg_now.ack_min, cfg_now.ack_max);
      end else if (rx_buf[POS_TYPE] == TYPE_DATA) begin
         hold_limit = next_delay(cfg_now.data_min, cfg_now.data_max);
      end
   endfunction

   function automatic void judge_packet();
      if (rx_buf[POS_TTL] == TTL_DROP) return;
      if (!slot_full) begin
         take_slot(1'b0);
      end else if (slot_buf[POS_TYPE] == TYPE_DATA) begin
         if (rx_buf[POS_TYPE] == TYPE_ACK && rx_buf[POS_SEQ] == slot_buf[POS_SEQ]) begin
            take_slot(1'b1);
         end else if (rx_buf[POS_SEQ] > slot_buf[POS_SEQ]) begin
            take_slot(1'b0);
         end
      end else if (slot_buf[POS_TYPE] == TYPE_ACK) begin
         if (rx_buf[POS_SEQ] > slot_buf[POS_SEQ]) take_slot(1'b0);
      end
   endfunction

   function automatic void relay_predict(input req_word_type w);
      rsp_word_type r;
      if (w.req_type == REQ_BYTE) begin
         rx_buf[rx_pos] = w.rx_byte;
         rx_pos++;
         if (rx_pos >= NBYTES) begin
            rx_pos = 0;
            judge_packet();
         end
      end else if (ticks_since != '1) begin
         ticks_since++;
      end
      if (slot_full && ticks_since >= hold_limit) begin
         for (int k = 0; k < NBYTES; k++) begin
            r.tx_byte = slot_buf[k];
            if (k == POS_ADDR) r.tx_byte = cfg_now.relay_id;
            else if (k == POS_TTL) r.tx_byte = slot_buf[k] - 8'd1;
            r.tx_last = (k == NBYTES - 1);
            forward_q.push_back(r);
         end
         slot_full = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (forward_q.size() == 0) begin
            note_error($sformatf("unexpected word byte %h last %b",
                                 rsp_word.tx_byte, rsp_word.tx_last));
         end else begin
            head_word = forward_q.pop_front();
            if (rsp_word.tx_byte !== head_word.tx_byte || rsp_word.tx_last !== head_word.tx_last)
            begin
               note_error($sformatf("word byte %h last %b, expected byte %h last %b",
                                    rsp_word.tx_byte, rsp_word.tx_last,
                                    head_word.tx_byte, head_word.tx_last));
            end
         end
      end
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff > 0) begin
            rsp_holdoff--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!rsp_eager && $urandom_range(0, 99) < 20) begin
            stall_left = idle_len() - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic kind, input logic [7:0] data);
      req_word_type w;
      w.req_type = kind;
      w.rx_byte = data;
      if (!req_eager && $urandom_range(0, 99) < 30) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (idle_len()) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      push <= 1'b1;
      req_word <= w;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      words_sent++;
      relay_predict(w);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(REQ_TICK, 8'($urandom));
   endtask

   task automatic send_packet(input logic [7:0] pkt_kind, input logic [7:0] seq,
                              input logic [7:0] ttl, input int fill = -1);
      logic [7:0] b;
      for (int k = 0; k < NBYTES; k++) begin
         b = (fill < 0) ? 8'($urandom) : 8'(fill);
         if (k == POS_TYPE) b = pkt_kind;
         else if (k == POS_SEQ) b = seq;
         else if (k == POS_TTL) b = ttl;
         send_word(REQ_BYTE, b);
      end
   endtask

   task automatic flush_slot();
      while (slot_full) send_word(REQ_TICK, 8'($urandom));
   endtask

   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (forward_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      logic [CSR_DATA_BITS-1:0] want;
      want = (idx == REG_RELAY_ID) ? CSR_DATA_BITS'(value[7:0]) : CSR_DATA_BITS'(value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= CSR_DATA_BITS'(value);
      @(negedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      case (idx)
         REG_RELAY_ID: cfg_now.relay_id = value[7:0];
         REG_DATA_MIN: cfg_now.data_min = value;
         REG_DATA_MAX: cfg_now.data_max = value;
         REG_ACK_MIN:  cfg_now.ack_min = value;
         REG_ACK_MAX:  cfg_now.ack_max = value;
         default: ;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      if (prdata !== want) begin
         note_error($sformatf("register %0d read %h, expected %h", idx, prdata, want));
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] id, input logic [15:0] dmin,
                             input logic [15:0] dmax, input logic [15:0] amin,
                             input logic [15:0] amax);
      drain();
      csr_write(REG_RELAY_ID, 16'(id));
      csr_write(REG_DATA_MIN, dmin);
      csr_write(REG_DATA_MAX, dmax);
      csr_write(REG_ACK_MIN, amin);
      csr_write(REG_ACK_MAX, amax);
   endtask

   task automatic test_zero_delay();
      set_config(8'h5A, 16'd0, 16'd0, 16'd0, 16'd0);
      send_packet(TYPE_DATA, 8'h00, 8'h01, 0);
      send_packet(8'hFF, 8'hFF, 8'hFF, 255);
      send_packet(TYPE_ACK, 8'h7F, TTL_DROP);
      send_word(REQ_TICK, 8'hFF);
      send_word(REQ_TICK, 8'h00);
   endtask

   task automatic test_replacement();
      set_config(8'hC3, 16'd3, 16'd3, 16'd2, 16'd6);
      send_packet(TYPE_DATA, 8'd10, 8'd4);
      send_ticks(1);
      send_packet(TYPE_ACK, 8'd10, 8'd4);
      flush_slot();
      send_packet(TYPE_DATA, 8'd10, 8'd9);
      send_packet(TYPE_DATA, 8'd9, 8'd9);
      send_packet(TYPE_DATA, 8'd11, 8'd9);
      flush_slot();
      send_packet(TYPE_ACK, 8'd20, 8'd2);
      send_packet(TYPE_DATA, 8'd20, 8'd2);
      send_packet(TYPE_ACK, 8'd20, 8'd2);
      send_packet(TYPE_ACK, 8'd19, 8'd2);
      send_packet(TYPE_DATA, 8'd21, 8'd2);
      flush_slot();
      send_packet(8'h33, 8'd5, 8'd7);
      send_packet(TYPE_DATA, 8'd200, 8'd7);
      send_packet(TYPE_ACK, 8'd5, 8'd7);
      flush_slot();
      set_config(8'h01, 16'd5, 16'd2, 16'd4, 16'd4);
      send_packet(TYPE_DATA, 8'd1, 8'd3);
      flush_slot();
      send_packet(TYPE_ACK, 8'd2, 8'd3);
      flush_slot();
   endtask

   task automatic test_extremes();
      set_config(8'hFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      send_packet(TYPE_DATA, 8'h80, 8'h10);
      send_ticks(3);
      set_config(8'h00, 16'd0, 16'hFFFF, 16'd0, 16'd0);
      send_packet(TYPE_ACK, 8'h80, 8'h10);
      send_packet(TYPE_DATA, 8'hFF, 8'h20);
      send_packet(TYPE_DATA, 8'hFF, 8'h20);
      send_ticks(2);
      set_config(8'hA5, 16'd0, 16'd0, 16'd0, 16'd1);
      send_packet(TYPE_ACK, 8'hFF, 8'h20);
      flush_slot();
   endtask

   task automatic test_backpressure();
      set_config(8'($urandom), 16'd0, 16'd0, 16'd0, 16'd0);
      req_eager = 1'b1;
      rsp_holdoff = 400;
      for (int i = 0; i < 6; i++) send_packet(TYPE_DATA, 8'(i), 8'($urandom_range(1, 255)));
      req_eager = 1'b0;
      drain();
   endtask

   task automatic send_random_packet();
      logic [7:0] pkt_kind;
      logic [7:0] seq;
      logic [7:0] ttl;
      int roll;
      roll = $urandom_range(0, 99);
      pkt_kind = (roll < 45) ? TYPE_DATA : (roll < 90) ? TYPE_ACK : 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 70) seq = seq_base + 8'($urandom_range(0, 1));
      else if (roll < 80) seq = seq_base - 8'd1;
      else seq = 8'($urandom);
      if ($urandom_range(0, 3) == 0) seq_base = seq_base + 8'd1;
      roll = $urandom_range(0, 99);
      ttl = (roll < 10) ? TTL_DROP : (roll < 20) ? 8'd1 : 8'($urandom_range(1, 255));
      send_packet(pkt_kind, seq, ttl);
   endtask

   task automatic test_random();
      int roll;
      int fill;
      while (words_sent < TOTAL_WORDS) begin
         set_config(8'($urandom), 16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                    16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)));
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(4, 8)) begin
            if (rx_pos != 0) begin
               fill = NBYTES - rx_pos;
               repeat (fill) send_word(REQ_BYTE, 8'($urandom));
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               send_word(REQ_BYTE, 8'($urandom));
            end else if (roll < 13) begin
               repeat ($urandom_range(1, NBYTES - 1)) send_word(REQ_BYTE, 8'($urandom));
            end else begin
               send_random_packet();
            end
            send_ticks($urandom_range(0, 6));
         end
         flush_slot();
         req_eager = 1'b0;
         rsp_eager = 1'b0;
         drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_zero_delay();
      test_replacement();
      test_extremes();
      test_backpressure();
      test_random();
      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
